// ===== src/sialu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sialu_pkg
// Shared codes and control types for the signed integer ALU with divide.
// ----------------------------------------------------------------------------
package sialu_pkg;

   localparam int DATA_WIDTH_DEF = 32;

   // operation codes
   localparam logic [3:0] CMD_POS = 4'd0;
   localparam logic [3:0] CMD_NEG = 4'd1;
   localparam logic [3:0] CMD_NOT = 4'd2;
   localparam logic [3:0] CMD_ADD = 4'd3;
   localparam logic [3:0] CMD_SUB = 4'd4;
   localparam logic [3:0] CMD_MUL = 4'd5;
   localparam logic [3:0] CMD_DIV = 4'd6;
   localparam logic [3:0] CMD_MOD = 4'd7;
   localparam logic [3:0] CMD_LT  = 4'd8;
   localparam logic [3:0] CMD_GT  = 4'd9;
   localparam logic [3:0] CMD_LE  = 4'd10;
   localparam logic [3:0] CMD_GE  = 4'd11;
   localparam logic [3:0] CMD_EQ  = 4'd12;
   localparam logic [3:0] CMD_NE  = 4'd13;
   localparam logic [3:0] CMD_AND = 4'd14;
   localparam logic [3:0] CMD_OR  = 4'd15;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
   localparam logic [1:0] ERR_MOD_ZERO = 2'd2;

   // control word that rides along the cell chain with each request
   typedef struct packed {
      logic       valid;
      logic       is_mul;    // shift-add step in each cell
      logic       is_div;    // restoring divide step in each cell
      logic       want_rem;  // deliver remainder instead of quotient
      logic       neg_q;     // quotient sign fix at the end
      logic       neg_r;     // remainder sign fix at the end
      logic [1:0] err;
   } sialu_ctrl_type;

endpackage

// ===== src/sialu_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sialu_cell
// One step of the arithmetic chain: a shift-add multiply step or a restoring
// divide step, registered and handed to the next cell.
// ----------------------------------------------------------------------------
module sialu_cell #(
   parameter int DATA_WIDTH = sialu_pkg::DATA_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sialu_pkg::sialu_ctrl_type  prev_ctrl,
   input  logic [DATA_WIDTH-1:0]      prev_x,
   input  logic [DATA_WIDTH-1:0]      prev_y,
   input  logic [DATA_WIDTH-1:0]      prev_acc,
   output sialu_pkg::sialu_ctrl_type  next_ctrl,
   output logic [DATA_WIDTH-1:0]      next_x,
   output logic [DATA_WIDTH-1:0]      next_y,
   output logic [DATA_WIDTH-1:0]      next_acc
);

   localparam int W = DATA_WIDTH;

   sialu_pkg::sialu_ctrl_type ctrl_ff, ctrl_in;
   logic [W-1:0] x_ff, x_in;
   logic [W-1:0] y_ff, y_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W+1:0] trial;

   // partial remainder with next dividend bit, minus divisor
   assign trial = {1'b0, prev_acc, prev_x[W-1]} - {2'b00, prev_y};

   always_comb begin
      ctrl_in = prev_ctrl;
      x_in    = prev_x;
      y_in    = prev_y;
      acc_in  = prev_acc;
      // simple commands take neither branch and pass through unchanged
      if (prev_ctrl.is_mul) begin
         if (prev_x[0]) begin
            acc_in = prev_acc + prev_y;
         end
         y_in = {prev_y[W-2:0], 1'b0};
         x_in = {1'b0, prev_x[W-1:1]};
      end else if (prev_ctrl.is_div) begin
         if (!trial[W+1]) begin
            acc_in = trial[W-1:0];
            x_in   = {prev_x[W-2:0], 1'b1};
         end else begin
            acc_in = {prev_acc[W-2:0], prev_x[W-1]};
            x_in   = {prev_x[W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign next_ctrl = ctrl_ff;
   assign next_x    = x_ff;
   assign next_y    = y_ff;
   assign next_acc  = acc_ff;

   // a request never runs both step kinds
   a_one_mode: assert property (@(posedge clock) disable iff (reset)
      !(ctrl_ff.is_mul && ctrl_ff.is_div))
      else $error("cell holds both multiply and divide");

   // valid moves one cell per cycle
   a_valid_moves: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (ctrl_ff.valid == $past(prev_ctrl.valid)))
      else $error("cell lost or invented a request");

   // restoring divide keeps the partial remainder below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (ctrl_ff.valid && ctrl_ff.is_div) |-> (acc_ff < y_ff))
      else $error("partial remainder not below divisor");

endmodule

// ===== src/signed_integer_alu_with_divide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_alu_with_divide
// Pipelined signed ALU; multiply and divide run through a chain of step cells.
// ----------------------------------------------------------------------------
// Path: from the accepting edge through the head register, the DATA_WIDTH step
//   cells and the result register, the same for every command.
// Throughput: one request per cycle; busy stays low, and with the head and result
//   registers the DATA_WIDTH step cells hold up to DATA_WIDTH + 2 requests in flight.
// Reset: synchronous, clears all valid flags in the chain and the strobe.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
module signed_integer_alu_with_divide #(
   parameter int DATA_WIDTH = sialu_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [3:0]                   req_command,
   input  logic signed [DATA_WIDTH-1:0] req_operand_a,
   input  logic signed [DATA_WIDTH-1:0] req_operand_b,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_result_value,
   output logic [1:0]                   rsp_error_code
);

   localparam int W = DATA_WIDTH;

   // ------------------------------------------------------------------------
   // Front end: decode, magnitudes and all single-step operations. The simple
   // results ride in the accumulator field and cells pass them untouched.
   // ------------------------------------------------------------------------
   sialu_pkg::sialu_ctrl_type head_ctrl_ff, head_ctrl_in;
   logic [W-1:0] head_x_ff, head_x_in;
   logic [W-1:0] head_y_ff, head_y_in;
   logic [W-1:0] head_acc_ff, head_acc_in;

   logic         accept;
   logic         a_neg, b_neg;
   logic [W-1:0] a_mag, b_mag;
   logic         a_nz, b_nz;

   assign busy   = 1'b0;   // fully pipelined, never refuses a request
   assign accept = start && !busy;

   assign a_neg = req_operand_a[W-1];
   assign b_neg = req_operand_b[W-1];
   // the minimum value maps onto the sign bit alone, which still fits
   assign a_mag = a_neg ? (W'(0) - req_operand_a) : req_operand_a;
   assign b_mag = b_neg ? (W'(0) - req_operand_b) : req_operand_b;
   assign a_nz  = (req_operand_a != '0);
   assign b_nz  = (req_operand_b != '0);

   always_comb begin
      head_ctrl_in       = '0;
      head_ctrl_in.valid = accept;
      head_ctrl_in.err   = sialu_pkg::ERR_NONE;
      head_x_in          = '0;
      head_y_in          = '0;
      head_acc_in        = '0;
      unique case (req_command)
         sialu_pkg::CMD_POS: head_acc_in = req_operand_a;
         sialu_pkg::CMD_NEG: head_acc_in = W'(0) - req_operand_a;
         sialu_pkg::CMD_NOT: head_acc_in = W'(!a_nz);
         sialu_pkg::CMD_ADD: head_acc_in = req_operand_a + req_operand_b;
         sialu_pkg::CMD_SUB: head_acc_in = req_operand_a - req_operand_b;
         sialu_pkg::CMD_MUL: begin
            // low half of the product is sign-agnostic
            head_ctrl_in.is_mul = 1'b1;
            head_x_in           = req_operand_b;
            head_y_in           = req_operand_a;
         end
         sialu_pkg::CMD_DIV: begin
            if (!b_nz) begin
               head_ctrl_in.err = sialu_pkg::ERR_DIV_ZERO;
            end else begin
               head_ctrl_in.is_div = 1'b1;
               head_ctrl_in.neg_q  = a_neg ^ b_neg;
               head_x_in           = a_mag;
               head_y_in           = b_mag;
            end
         end
         sialu_pkg::CMD_MOD: begin
            if (!b_nz) begin
               head_ctrl_in.err = sialu_pkg::ERR_MOD_ZERO;
            end else begin
               head_ctrl_in.is_div   = 1'b1;
               head_ctrl_in.want_rem = 1'b1;
               head_ctrl_in.neg_r    = a_neg;   // remainder follows dividend
               head_x_in             = a_mag;
               head_y_in             = b_mag;
            end
         end
         sialu_pkg::CMD_LT:  head_acc_in = W'(req_operand_a < req_operand_b);
         sialu_pkg::CMD_GT:  head_acc_in = W'(req_operand_b < req_operand_a);
         sialu_pkg::CMD_LE:  head_acc_in = W'(!(req_operand_b < req_operand_a));
         sialu_pkg::CMD_GE:  head_acc_in = W'(!(req_operand_a < req_operand_b));
         sialu_pkg::CMD_EQ:  head_acc_in = W'(req_operand_a == req_operand_b);
         sialu_pkg::CMD_NE:  head_acc_in = W'(req_operand_a != req_operand_b);
         sialu_pkg::CMD_AND: head_acc_in = W'(a_nz && b_nz);
         sialu_pkg::CMD_OR:  head_acc_in = W'(a_nz || b_nz);
         default:            head_acc_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ctrl_ff <= '0;
      end else begin
         head_ctrl_ff <= head_ctrl_in;
      end
      head_x_ff   <= head_x_in;
      head_y_ff   <= head_y_in;
      head_acc_ff <= head_acc_in;
   end

   // ------------------------------------------------------------------------
   // Cell chain: one multiply or divide bit per cell. After W cells the
   // accumulator holds the product (or remainder) and x the quotient.
   // ------------------------------------------------------------------------
   sialu_pkg::sialu_ctrl_type chain_ctrl [0:W];
   logic [W-1:0] chain_x   [0:W];
   logic [W-1:0] chain_y   [0:W];
   logic [W-1:0] chain_acc [0:W];

   assign chain_ctrl[0] = head_ctrl_ff;
   assign chain_x[0]    = head_x_ff;
   assign chain_y[0]    = head_y_ff;
   assign chain_acc[0]  = head_acc_ff;

   for (genvar i = 0; i < W; i++) begin : g_cell
      sialu_cell #(
         .DATA_WIDTH (W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_ctrl (chain_ctrl[i]),
         .prev_x    (chain_x[i]),
         .prev_y    (chain_y[i]),
         .prev_acc  (chain_acc[i]),
         .next_ctrl (chain_ctrl[i+1]),
         .next_x    (chain_x[i+1]),
         .next_y    (chain_y[i+1]),
         .next_acc  (chain_acc[i+1])
      );
   end

   // ------------------------------------------------------------------------
   // Back end: sign fix for divide/remainder, then the result register.
   // ------------------------------------------------------------------------
   sialu_pkg::sialu_ctrl_type tail_ctrl;
   logic [W-1:0] tail_mag;
   logic         tail_neg;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_result_ff, rsp_result_in;
   logic [1:0]   rsp_error_ff, rsp_error_in;

   assign tail_ctrl = chain_ctrl[W];

   always_comb begin
      tail_mag = chain_acc[W];
      tail_neg = 1'b0;
      if (tail_ctrl.is_div) begin
         if (tail_ctrl.want_rem) begin
            tail_mag = chain_acc[W];
            tail_neg = tail_ctrl.neg_r;
         end else begin
            tail_mag = chain_x[W];
            tail_neg = tail_ctrl.neg_q;
         end
      end
      rsp_valid_in  = tail_ctrl.valid;
      rsp_result_in = tail_neg ? (W'(0) - tail_mag) : tail_mag;
      rsp_error_in  = tail_ctrl.err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_result_ff <= rsp_result_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_result_ff;
   assign rsp_error_code   = rsp_error_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // every request leaving the chain shows up as exactly one strobe
   a_tail_to_rsp: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_valid_ff == $past(tail_ctrl.valid)))
      else $error("result strobe does not follow chain tail");

   // an error result carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_error_ff != sialu_pkg::ERR_NONE)) |->
         (rsp_result_ff == '0))
      else $error("error result with nonzero value");

   // a request with an error code never enters a multi-step mode
   a_err_bypass: assert property (@(posedge clock) disable iff (reset)
      (head_ctrl_ff.valid && (head_ctrl_ff.err != sialu_pkg::ERR_NONE)) |->
         (!head_ctrl_ff.is_div && !head_ctrl_ff.is_mul))
      else $error("faulted request routed through divide or multiply");

   // an accepted request reaches the chain head on the next edge
   a_head_load: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (head_ctrl_ff.valid == $past(accept)))
      else $error("accepted request missing at chain head");

endmodule
